// File: sv/qcpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quad clip-plane classifier.
// No dependencies; every other file takes its names from here.
package qcpc_pkg;

    // Data word, plane and corner counts
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned NUM_CORNERS   = 4;
    localparam int unsigned NUM_PLANES    = 4;
    localparam int unsigned NUM_XZ_PLANES = 2;
    localparam int unsigned COEFS_PER_PLANE = 2;
    localparam int unsigned NUM_REGS      = NUM_PLANES * COEFS_PER_PLANE;

    // Configuration index is one bit wider than the register file needs,
    // so that writes beyond the last register can be seen and dropped
    localparam int unsigned REG_SEL_W = $clog2(NUM_REGS);
    localparam int unsigned CFG_IDX_W = REG_SEL_W + 1;

    // Count of adjacent negative pairs around the quad, 0..NUM_CORNERS
    localparam int unsigned CNT_W = $clog2(NUM_CORNERS + 1);
    localparam int unsigned CORNER_SEL_W = $clog2(NUM_CORNERS);

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } corner_t;

    // Coefficient pair of one side plane: lateral axis and depth
    typedef struct packed {
        word_t coord_coef;
        word_t z_coef;
    } plane_t;

    typedef enum logic [1:0] {
        CLASS_OUTSIDE  = 2'd0,
        CLASS_CROSSING = 2'd1,
        CLASS_INSIDE   = 2'd2
    } class_t;

    // Lateral coordinate seen by a plane: x for the x/z planes, y otherwise
    function automatic word_t plane_coord(corner_t c, int unsigned plane);
        word_t r;
        if (plane < NUM_XZ_PLANES)
        begin
            r = c.x;
        end
        else
        begin
            r = c.y;
        end
        return r;
    endfunction

endpackage

// File: sv/quad_clip_plane_classifier.sv
`timescale 1ns / 1ps
// Quad clip-plane classifier, top level.
// Depends on qcpc_pkg, qcpc_cfg_regs and the three qcpc pipeline stages.
//
// Usage:
// - Input channel: in_valid with the twelve corner coordinates; the block
//   drives in_stall. A transaction is taken at an edge with in_valid high
//   and in_stall low.
// - Output channel: out_valid with quad_class; the receiver drives out_stall.
// - Configuration: eight plane coefficients written through cfg_we,
//   cfg_index and cfg_data, only while the pipeline is empty. Indexes
//   beyond seven are dropped.
// - Pipeline: three register stages (products, distance signs, class and
//   output register). A quad moves through them in that order and can be
//   held in any of them while a later stage stalls.
// - Throughput: one quad per cycle unless stalled; every plane/corner product
//   has its own first-stage multiplier, so no unit is shared between items.
// - Reset clears all valid bits and the coefficients to zero.
// - When the receiver stalls, the result holds; earlier stages keep filling
//   any empty slot, and in_stall rises only once every stage is occupied.
module quad_clip_plane_classifier
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [qcpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [31:0]             corner0_x,
    input  logic signed [31:0]             corner0_y,
    input  logic signed [31:0]             corner0_z,
    input  logic signed [31:0]             corner1_x,
    input  logic signed [31:0]             corner1_y,
    input  logic signed [31:0]             corner1_z,
    input  logic signed [31:0]             corner2_x,
    input  logic signed [31:0]             corner2_y,
    input  logic signed [31:0]             corner2_z,
    input  logic signed [31:0]             corner3_x,
    input  logic signed [31:0]             corner3_y,
    input  logic signed [31:0]             corner3_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     quad_class
);

    qcpc_pkg::plane_t  planes  [qcpc_pkg::NUM_PLANES];
    qcpc_pkg::corner_t corners [qcpc_pkg::NUM_CORNERS];

    qcpc_pkg::word_t prod_coord [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS];
    qcpc_pkg::word_t prod_z     [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS];
    logic [qcpc_pkg::NUM_CORNERS-1:0] neg [qcpc_pkg::NUM_PLANES];

    logic             s1_ready;
    logic             s1_valid;
    logic             s2_ready;
    logic             s2_valid;
    logic             s3_ready;
    qcpc_pkg::class_t class_out;

    // Gather the corner ports
    assign corners[0] = '{x: $unsigned(corner0_x), y: $unsigned(corner0_y),
                          z: $unsigned(corner0_z)};
    assign corners[1] = '{x: $unsigned(corner1_x), y: $unsigned(corner1_y),
                          z: $unsigned(corner1_z)};
    assign corners[2] = '{x: $unsigned(corner2_x), y: $unsigned(corner2_y),
                          z: $unsigned(corner2_z)};
    assign corners[3] = '{x: $unsigned(corner3_x), y: $unsigned(corner3_y),
                          z: $unsigned(corner3_z)};

    qcpc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    qcpc_product_stage u_product_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (s1_ready),
        .corners    (corners),
        .planes     (planes),
        .out_valid  (s1_valid),
        .out_ready  (s2_ready),
        .prod_coord (prod_coord),
        .prod_z     (prod_z)
    );

    qcpc_sign_stage u_sign_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid),
        .in_ready   (s2_ready),
        .prod_coord (prod_coord),
        .prod_z     (prod_z),
        .out_valid  (s2_valid),
        .out_ready  (s3_ready),
        .neg        (neg)
    );

    qcpc_class_stage u_class_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s3_ready),
        .neg        (neg),
        .out_valid  (out_valid),
        .out_ready  (!out_stall),
        .quad_class (class_out)
    );

    assign in_stall   = !s1_ready;
    assign quad_class = class_out;

    // An empty pipeline never refuses a transaction
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid && !s2_valid && !out_valid) |-> !in_stall)
        else $error("pipeline empty but input stalled");

    // A sign result moving on shows up at the output next cycle
    a_sign_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && s3_ready) |=> out_valid)
        else $error("transaction lost between sign and class stages");

    // The input only stalls when every stage holds an item and the output is stuck
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
        else $error("input stalled with a free pipeline slot");

    // A shown class is always one of the three defined codes
    a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quad_class == qcpc_pkg::CLASS_OUTSIDE ||
                       quad_class == qcpc_pkg::CLASS_CROSSING ||
                       quad_class == qcpc_pkg::CLASS_INSIDE))
        else $error("undefined class code on output");

endmodule

// File: sv/qcpc_cfg_regs.sv
`timescale 1ns / 1ps
// Plane coefficient register file, written through the configuration port.
// Depends on qcpc_pkg for widths and the plane type.
module qcpc_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [qcpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  qcpc_pkg::word_t               cfg_data,
    output qcpc_pkg::plane_t              planes [qcpc_pkg::NUM_PLANES]
);

    qcpc_pkg::word_t regs_reg [qcpc_pkg::NUM_REGS];
    logic            hit;

    // Drop writes beyond the last register
    assign hit = cfg_we &&
                 (cfg_index < qcpc_pkg::CFG_IDX_W'(qcpc_pkg::NUM_REGS));

    // Hold the coefficients; clear to zero at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < qcpc_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (hit)
        begin
            regs_reg[cfg_index[qcpc_pkg::REG_SEL_W-1:0]] <= cfg_data;
        end
    end

    // Pair the registers up per plane: lateral coefficient, then depth
    for (genvar p = 0; p < qcpc_pkg::NUM_PLANES; p++)
    begin : g_plane
        assign planes[p].coord_coef = regs_reg[p * qcpc_pkg::COEFS_PER_PLANE];
        assign planes[p].z_coef     = regs_reg[p * qcpc_pkg::COEFS_PER_PLANE + 1];
    end

endmodule

// File: sv/qcpc_product_stage.sv
`timescale 1ns / 1ps
// First pipeline stage: the thirty-two plane/corner products, low 32 bits each.
// Depends on qcpc_pkg for corner and plane types.
module qcpc_product_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qcpc_pkg::corner_t corners    [qcpc_pkg::NUM_CORNERS],
    input  qcpc_pkg::plane_t  planes     [qcpc_pkg::NUM_PLANES],
    output logic              out_valid,
    input  logic              out_ready,
    output qcpc_pkg::word_t   prod_coord [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS],
    output qcpc_pkg::word_t   prod_z     [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS]
);

    logic            valid_reg;
    qcpc_pkg::word_t coord_reg  [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS];
    qcpc_pkg::word_t z_reg      [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS];
    qcpc_pkg::word_t coord_next [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS];
    qcpc_pkg::word_t z_next     [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS];

    // Advance whenever the stage is empty or its content moves on
    assign in_ready = !valid_reg || out_ready;

    // Multiply in a 32-bit context so only the low half of each product is kept
    always_comb
    begin
        for (int p = 0; p < qcpc_pkg::NUM_PLANES; p++)
        begin
            for (int c = 0; c < qcpc_pkg::NUM_CORNERS; c++)
            begin
                coord_next[p][c] = qcpc_pkg::plane_coord(corners[c], p)
                                   * planes[p].coord_coef;
                z_next[p][c]     = corners[c].z * planes[p].z_coef;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the products only with a real transaction
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            coord_reg <= coord_next;
            z_reg     <= z_next;
        end
    end

    assign out_valid  = valid_reg;
    assign prod_coord = coord_reg;
    assign prod_z     = z_reg;

endmodule

// File: sv/qcpc_sign_stage.sv
`timescale 1ns / 1ps
// Second pipeline stage: wrap-around sum of the two products per plane and
// corner, reduced to its sign. Depends on qcpc_pkg.
module qcpc_sign_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  qcpc_pkg::word_t                     prod_coord [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS],
    input  qcpc_pkg::word_t                     prod_z     [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS],
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [qcpc_pkg::NUM_CORNERS-1:0]    neg        [qcpc_pkg::NUM_PLANES]
);

    logic                             valid_reg;
    logic [qcpc_pkg::NUM_CORNERS-1:0] neg_reg  [qcpc_pkg::NUM_PLANES];
    logic [qcpc_pkg::NUM_CORNERS-1:0] neg_next [qcpc_pkg::NUM_PLANES];
    qcpc_pkg::word_t                  sum      [qcpc_pkg::NUM_PLANES][qcpc_pkg::NUM_CORNERS];

    assign in_ready = !valid_reg || out_ready;

    // The distance sign is the top bit of the wrap-around sum
    always_comb
    begin
        for (int p = 0; p < qcpc_pkg::NUM_PLANES; p++)
        begin
            for (int c = 0; c < qcpc_pkg::NUM_CORNERS; c++)
            begin
                sum[p][c]      = prod_coord[p][c] + prod_z[p][c];
                neg_next[p][c] = sum[p][c][qcpc_pkg::WORD_W-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            neg_reg <= neg_next;
        end
    end

    assign out_valid = valid_reg;
    assign neg       = neg_reg;

endmodule

// File: sv/qcpc_class_stage.sv
`timescale 1ns / 1ps
// Third pipeline stage and output register: counts negative corner pairs
// around the quad per plane and picks the class. Depends on qcpc_pkg.
module qcpc_class_stage
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [qcpc_pkg::NUM_CORNERS-1:0] neg [qcpc_pkg::NUM_PLANES],
    output logic                             out_valid,
    input  logic                             out_ready,
    output qcpc_pkg::class_t                 quad_class
);

    // Walk the outline as corners 0, 1, 3, 2 and back to 0
    localparam logic [qcpc_pkg::CORNER_SEL_W-1:0] RING_ORDER [qcpc_pkg::NUM_CORNERS] =
        '{2'd0, 2'd1, 2'd3, 2'd2};

    logic                        valid_reg;
    qcpc_pkg::class_t            class_reg;
    qcpc_pkg::class_t            class_next;
    logic [qcpc_pkg::CNT_W-1:0]  count [qcpc_pkg::NUM_PLANES];
    logic                        any_outside;
    logic                        any_pair;

    assign in_ready = !valid_reg || out_ready;

    // Count edges whose two end corners are both behind the plane
    always_comb
    begin
        any_outside = 1'b0;
        any_pair    = 1'b0;
        for (int p = 0; p < qcpc_pkg::NUM_PLANES; p++)
        begin
            count[p] = '0;
            for (int k = 0; k < qcpc_pkg::NUM_CORNERS; k++)
            begin
                count[p] = count[p] + qcpc_pkg::CNT_W'(
                    neg[p][RING_ORDER[k]] &&
                    neg[p][RING_ORDER[(k + 1) % qcpc_pkg::NUM_CORNERS]]);
            end
            if (count[p] == qcpc_pkg::CNT_W'(qcpc_pkg::NUM_CORNERS))
            begin
                any_outside = 1'b1;
            end
            if (count[p] != '0)
            begin
                any_pair = 1'b1;
            end
        end
        if (any_outside)
        begin
            class_next = qcpc_pkg::CLASS_OUTSIDE;
        end
        else if (!any_pair)
        begin
            class_next = qcpc_pkg::CLASS_INSIDE;
        end
        else
        begin
            class_next = qcpc_pkg::CLASS_CROSSING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            class_reg <= class_next;
        end
    end

    assign out_valid  = valid_reg;
    assign quad_class = class_reg;

endmodule
